### hw/rtl/fca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, constants and helpers of the chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int SECT_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = SECT_W + 1;

    typedef logic [SECT_W-1:0] sect_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_WALK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_ZERO_CNT  = 2'd2,
        ST_UNUSED    = 2'd3
    } status_t;

    localparam sect_t LINK_END  = '0;
    localparam sect_t LINK_FREE = sect_t'(1);
    localparam logic signed [CNT_W-1:0] NONE_FREE = '1;

    typedef struct packed {
        logic  en;
        sect_t addr;
    } ram_rd_t;

    typedef struct packed {
        logic  en;
        sect_t addr;
        sect_t data;
    } ram_wr_t;

    typedef struct packed {
        logic    push;
        sect_t   sector;
        logic    last;
        status_t status;
    } result_t;

    // Value an entry holds after reset or clear; also what freeing writes.
    function automatic sect_t link_reset(input sect_t addr);
        return (addr < sect_t'(2)) ? LINK_END : LINK_FREE;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/fca_link_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fca_link_ram
// Link table: one write and one read port, registered read data, per-entry
// valid bits for the reset pattern and write-to-read forwarding.
// ----------------------------------------------------------------------------
module fca_link_ram
    import fca_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    clr,
    input  wire ram_rd_t rd,
    input  wire ram_wr_t wr,
    output logic [SECT_W-1:0] rd_data
);

    sect_t                     mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  vld_reg;
    sect_t                     q_reg;
    sect_t                     addr_q_reg;
    logic                      vld_q_reg;
    logic                      fwd_hit_reg;
    sect_t                     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg        <= mem[rd.addr];
            addr_q_reg   <= rd.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_q_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (rd.en)
            begin
                vld_q_reg   <= vld_reg[rd.addr];
                fwd_hit_reg <= wr.en && (wr.addr == rd.addr);
            end
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as their reset value; a same-cycle write wins.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (vld_q_reg)
        begin
            rd_data = q_reg;
        end
        else
        begin
            rd_data = link_reset(addr_q_reg);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fca_ctrl
// Sequencer: clear, allocate, free, walk on the link table; all but walk and
// refused allocate end in the summary scan: free count, lowest free sector.
// ----------------------------------------------------------------------------
module fca_ctrl
    import fca_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire action_t action,
    input  wire sect_t   head_sector,
    input  wire cnt_t    count,
    output logic         clr,
    output ram_rd_t      rd,
    output ram_wr_t      wr,
    input  wire sect_t   rd_data,
    input  wire logic    slot_free,
    output result_t      res,
    output cnt_t         free_count,
    output logic signed [CNT_W-1:0] first_free
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_END,
        S_FREE,
        S_WALK,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    sect_t   head_reg, head_next;
    sect_t   cur_reg, cur_next;
    sect_t   prev_reg, prev_next;
    cnt_t    cnt_reg, cnt_next;
    cnt_t    remain_reg, remain_next;
    status_t status_reg, status_next;
    cnt_t    fc_reg, fc_next;
    logic signed [CNT_W-1:0] ff_reg, ff_next;

    sect_t   eval_idx;
    logic    link_stop;
    logic    cnt_top;

    assign eval_idx   = SECT_W'(cnt_reg - cnt_t'(1));
    assign link_stop  = (rd_data == LINK_END) || (rd_data == LINK_FREE);
    assign cnt_top    = (cnt_reg == cnt_t'(TABLE_ENTRIES - 1));
    assign free_count = fc_reg;
    assign first_free = ff_reg;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        status_next = status_reg;
        fc_next     = fc_reg;
        ff_next     = ff_reg;
        in_ready    = 1'b0;
        clr         = 1'b0;
        rd          = '0;
        wr          = '0;
        res         = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    head_next   = head_sector;
                    cur_next    = head_sector;
                    prev_next   = head_sector;
                    cnt_next    = '0;
                    status_next = ST_OK;
                    remain_next = count - cnt_t'(1);
                    case (action)
                        ACT_CLEAR:
                        begin
                            clr        = 1'b1;
                            state_next = S_SCAN;
                        end
                        ACT_ALLOC:
                        begin
                            if (count == '0)
                            begin
                                status_next = ST_ZERO_CNT;
                                state_next  = S_RESULT;
                            end
                            else if (count > fc_reg)
                            begin
                                status_next = ST_NO_SPACE;
                                state_next  = S_RESULT;
                            end
                            else if (count == cnt_t'(1))
                            begin
                                wr.en      = 1'b1;
                                wr.addr    = head_sector;
                                wr.data    = LINK_END;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        ACT_FREE:
                        begin
                            rd.en      = 1'b1;
                            rd.addr    = head_sector;
                            state_next = S_FREE;
                        end
                        ACT_WALK:
                        begin
                            rd.en      = 1'b1;
                            rd.addr    = head_sector;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                // Read ahead one entry; link the previous one if it is free.
                if (cnt_reg < cnt_t'(TABLE_ENTRIES))
                begin
                    rd.en   = 1'b1;
                    rd.addr = cnt_reg[SECT_W-1:0];
                end
                cnt_next = cnt_reg + cnt_t'(1);
                if (cnt_reg != '0 && rd_data == LINK_FREE && eval_idx != head_reg)
                begin
                    wr.en       = 1'b1;
                    wr.addr     = prev_reg;
                    wr.data     = eval_idx;
                    prev_next   = eval_idx;
                    remain_next = remain_reg - cnt_t'(1);
                    if (remain_reg == cnt_t'(1))
                    begin
                        state_next = S_ALLOC_END;
                    end
                end
                if (cnt_reg == cnt_t'(TABLE_ENTRIES) && state_next == S_ALLOC)
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_ALLOC_END:
            begin
                wr.en      = 1'b1;
                wr.addr    = prev_reg;
                wr.data    = LINK_END;
                cnt_next   = '0;
                state_next = S_SCAN;
            end

            S_FREE:
            begin
                wr.en   = 1'b1;
                wr.addr = cur_reg;
                wr.data = link_reset(cur_reg);
                if (link_stop || cnt_top)
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    rd.en    = 1'b1;
                    rd.addr  = rd_data;
                    cur_next = rd_data;
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end

            S_WALK:
            begin
                if (slot_free)
                begin
                    res.push   = 1'b1;
                    res.sector = cur_reg;
                    res.last   = link_stop || cnt_top;
                    res.status = ST_OK;
                    if (link_stop || cnt_top)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd.en    = 1'b1;
                        rd.addr  = rd_data;
                        cur_next = rd_data;
                        cnt_next = cnt_reg + cnt_t'(1);
                    end
                end
            end

            S_SCAN:
            begin
                if (cnt_reg < cnt_t'(TABLE_ENTRIES))
                begin
                    rd.en   = 1'b1;
                    rd.addr = cnt_reg[SECT_W-1:0];
                end
                cnt_next = cnt_reg + cnt_t'(1);
                if (cnt_reg == '0)
                begin
                    fc_next = '0;
                    ff_next = NONE_FREE;
                end
                else if (rd_data == LINK_FREE)
                begin
                    fc_next = fc_reg + cnt_t'(1);
                    if (ff_reg == NONE_FREE)
                    begin
                        ff_next = signed'({1'b0, eval_idx});
                    end
                end
                if (cnt_reg == cnt_t'(TABLE_ENTRIES))
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (slot_free)
                begin
                    res.push   = 1'b1;
                    res.sector = head_reg;
                    res.last   = 1'b1;
                    res.status = status_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            fc_reg     <= cnt_t'(TABLE_ENTRIES - 2);
            ff_reg     <= CNT_W'(2);
            status_reg <= ST_OK;
            head_reg   <= '0;
            cur_reg    <= '0;
            prev_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            fc_reg     <= fc_next;
            ff_reg     <= ff_next;
            status_reg <= status_next;
            head_reg   <= head_next;
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            remain_reg <= remain_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fat_chain_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_allocator_unit
// Sector link table with chain allocate, free and walk over a stream port.
// ----------------------------------------------------------------------------
// The 32-entry link table sits in a one-read, one-write RAM with registered
// read data; all actions step through it one entry per cycle, a walk only
// while the output register can take its word, so the block takes one word
// at a time and holds s_axis_tready low until the action has run. Clear and
// a one-sector allocate run the accept step, the summary scan and the result
// step; an allocate of two or more sectors runs accept, a pass over the
// table that ends once the last sector is linked, the end-of-chain write,
// the scan and the result; a refused allocate runs accept and result; free
// runs accept, one step per chained sector, the scan and the result; a walk
// runs accept and one step per sector emitted. The result step and every
// walk step also wait while the output register holds a word the sink has
// not taken.
// The summary scan reads every entry to refresh the free count and lowest
// free sector reported in each result word. Entries come out of reset in
// their reset pattern through per-entry valid bits, so no clearing pass is
// needed and clear is as cheap as one scan. Results leave through an output
// register: a new input word is taken while the last result still waits.
// ----------------------------------------------------------------------------
module fat_chain_allocator_unit
    import fca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[1:0], head_sector[6:2], count[12:7], zero fill
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sector[4:0], free_count[10:5], first_free[16:11], status[18:17], zero fill
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    ram_rd_t rd;
    ram_wr_t wr;
    sect_t   rd_data;
    logic    clr;
    result_t res;
    cnt_t    free_count;
    logic signed [CNT_W-1:0] first_free;
    logic    slot_free;

    logic    out_valid_reg;
    sect_t   out_sector_reg;
    logic    out_last_reg;
    cnt_t    out_fc_reg;
    logic signed [CNT_W-1:0] out_ff_reg;
    status_t out_status_reg;

    // Output slot may be reloaded when empty or being drained this cycle.
    assign slot_free = !out_valid_reg || m_axis_tready;

    fca_link_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    fca_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (action_t'(s_axis_tdata[1:0])),
        .head_sector  (s_axis_tdata[6:2]),
        .count        (s_axis_tdata[12:7]),
        .clr          (clr),
        .rd           (rd),
        .wr           (wr),
        .rd_data      (rd_data),
        .slot_free    (slot_free),
        .res          (res),
        .free_count   (free_count),
        .first_free   (first_free)
    );

    // Hold the result word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            out_sector_reg <= res.sector;
            out_last_reg   <= res.last;
            out_fc_reg     <= free_count;
            out_ff_reg     <= first_free;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_status_reg, out_ff_reg, out_fc_reg, out_sector_reg};

endmodule
`default_nettype wire
